>>> rtl/core/field_period_turn_scheduler_macros.svh
// Assertion macros used by the field period turn scheduler RTL.
`ifndef FIELD_PERIOD_TURN_SCHEDULER_MACROS_SVH
`define FIELD_PERIOD_TURN_SCHEDULER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FPTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define FPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/core/fpts_pkg.sv
// Types and constants of the field period turn scheduler.
package fpts_pkg;

  localparam int unsigned TickW   = 64;
  localparam int unsigned PeriodW = 24;

  // Operation codes carried in the input word's user field.
  typedef enum logic [2:0] {
    FUNC_ARM       = 3'd0,
    FUNC_POLL      = 3'd1,
    FUNC_QUERY     = 3'd2,
    FUNC_NOTIFY    = 3'd3,
    FUNC_SVC_BEGIN = 3'd4,
    FUNC_SVC_END   = 3'd5
  } func_e;

  // Outcome codes carried in the result word's user field.
  typedef enum logic [2:0] {
    OUT_NONE      = 3'd0,
    OUT_SERVED    = 3'd1,
    OUT_MASKED    = 3'd2,
    OUT_NESTED    = 3'd3,
    OUT_BUSY      = 3'd4,
    OUT_NOT_OWNER = 3'd5
  } outcome_e;

  // Register indexes of the configuration channel.
  localparam logic CFG_REGISTERED = 1'b0;
  localparam logic CFG_PERIOD     = 1'b1;

  typedef struct packed {
    func_e              func;
    logic [TickW-1:0]   now_ticks;
    logic               core_match;
    logic               in_interrupt;
    logic               irq_on;
    logic               dispatch_busy;
  } item_t;

  typedef struct packed {
    logic               pending_out;
    logic               invoke_handler;
    logic [TickW-1:0]   ticks_until_due;
    outcome_e           outcome;
  } result_t;

  typedef struct packed {
    logic               registered;
    logic [PeriodW-1:0] period_ticks;
  } cfg_t;

  typedef struct packed {
    logic               pending;
    logic               in_turn;
  } status_t;

endpackage

>>> rtl/core/fpts_core.sv
// Scheduler state registers and the combinational operation logic.
module fpts_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  fpts_pkg::item_t  item_i,
  input  fpts_pkg::cfg_t   cfg_i,
  output fpts_pkg::result_t result_o,
  output fpts_pkg::status_t status_o
);

  logic [fpts_pkg::TickW-1:0] deadline_q, deadline_d;
  logic                       pending_q, pending_d;
  logic                       in_turn_q, in_turn_d;

  logic                       owner;
  logic [fpts_pkg::TickW-1:0] eff_period;
  logic [fpts_pkg::TickW-1:0] next_deadline;
  logic [fpts_pkg::TickW-1:0] ticks_left;
  logic                       reached;

  // Shared arithmetic: restart sum, deadline compare and remaining ticks.
  assign owner         = cfg_i.registered & item_i.core_match;
  assign eff_period    = (cfg_i.period_ticks == '0) ? fpts_pkg::TickW'(1)
                                                    : fpts_pkg::TickW'(cfg_i.period_ticks);
  assign next_deadline = item_i.now_ticks + eff_period;
  assign reached       = item_i.now_ticks >= deadline_q;
  assign ticks_left    = deadline_q - item_i.now_ticks;

  // Operation decode and next state.
  always_comb begin
    deadline_d = deadline_q;
    pending_d  = pending_q;
    in_turn_d  = in_turn_q;
    result_o.invoke_handler  = 1'b0;
    result_o.ticks_until_due = '0;
    result_o.outcome         = fpts_pkg::OUT_NONE;
    unique case (item_i.func)
      fpts_pkg::FUNC_ARM: begin
        if (cfg_i.registered) begin
          deadline_d = next_deadline;
        end else begin
          result_o.outcome = fpts_pkg::OUT_NOT_OWNER;
        end
      end
      fpts_pkg::FUNC_POLL: begin
        if (!owner) begin
          result_o.outcome = fpts_pkg::OUT_NOT_OWNER;
        end else if (reached) begin
          pending_d = 1'b1;
        end
      end
      fpts_pkg::FUNC_QUERY: begin
        if (!owner) begin
          result_o.ticks_until_due = '1;
          result_o.outcome         = fpts_pkg::OUT_NOT_OWNER;
        end else if (!reached) begin
          result_o.ticks_until_due = ticks_left;
        end
      end
      fpts_pkg::FUNC_NOTIFY: begin
        if (!owner) begin
          result_o.outcome = fpts_pkg::OUT_NOT_OWNER;
        end else begin
          deadline_d = next_deadline;
          pending_d  = 1'b0;
        end
      end
      fpts_pkg::FUNC_SVC_BEGIN: begin
        if (item_i.in_interrupt || !item_i.irq_on) begin
          result_o.outcome = fpts_pkg::OUT_MASKED;
        end else if (owner && in_turn_q) begin
          result_o.outcome = fpts_pkg::OUT_NESTED;
        end else if (item_i.dispatch_busy) begin
          result_o.outcome = fpts_pkg::OUT_BUSY;
        end else if (!owner) begin
          result_o.outcome = fpts_pkg::OUT_NOT_OWNER;
        end else begin
          pending_d = 1'b0;
          in_turn_d = 1'b1;
          result_o.invoke_handler = 1'b1;
          result_o.outcome        = fpts_pkg::OUT_SERVED;
        end
      end
      fpts_pkg::FUNC_SVC_END: begin
        if (!owner) begin
          result_o.outcome = fpts_pkg::OUT_NOT_OWNER;
        end else if (in_turn_q) begin
          in_turn_d = 1'b0;
          if (reached) begin
            deadline_d = next_deadline;
          end
        end
      end
      default: begin
      end
    endcase
    result_o.pending_out = pending_d;
  end

  // State update when a word leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadline_q <= '0;
      pending_q  <= 1'b0;
      in_turn_q  <= 1'b0;
    end else if (fire_i) begin
      deadline_q <= deadline_d;
      pending_q  <= pending_d;
      in_turn_q  <= in_turn_d;
    end
  end

  assign status_o.pending = pending_q;
  assign status_o.in_turn = in_turn_q;

endmodule

>>> rtl/core/field_period_turn_scheduler.sv
// Top level of the field period turn scheduler: stream channels and config.
//
// The slave stream carries one operation word per handshake: the operation
// code in tuser and the tick count plus guest flags in tdata. Every accepted
// word produces exactly one result word on the master stream, with the
// outcome code in tuser and pending, invoke and ticks-until-due in tdata.
// A word is registered on input, evaluated against the deadline, pending
// and turn state, and lands in the output register, where the result is
// held until the master stream takes it. One word is taken per cycle for
// as long as the output is drained; the deadline compare and restart add
// that update the state are combinational. The configuration channel is
// always ready; index 0 writes the registered flag and index 1 the period
// in ticks. It is to be written only while idle; the block itself does
// not enforce this. Reset clears the deadline, pending request and open
// turn, clears the registered flag and sets the period to one tick. When
// the receiver stalls the result holds in the output register, the input
// register fills once, and tready then drops until the result is taken.
`include "field_period_turn_scheduler_macros.svh"

module field_period_turn_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // now_ticks[63:0], core_match[64], in_interrupt[65], irq_on[66],
  // dispatch_busy[67], zero fill[71:68]
  input  logic [71:0] s_axis_tdata_i,
  // func[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // pending_out[0], invoke_handler[1], ticks_until_due[65:2], zero fill[71:66]
  output logic [71:0] m_axis_tdata_o,
  // outcome[2:0]
  output logic [2:0]  m_axis_tuser_o,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  logic                 in_valid_q;
  fpts_pkg::item_t      in_item_q;
  logic                 out_valid_q;
  fpts_pkg::result_t    out_res_q;
  fpts_pkg::result_t    core_res;
  fpts_pkg::status_t    core_status;
  fpts_pkg::cfg_t       cfg_q;
  logic                 fire;
  logic                 in_accept;

  // Handshake: the input register advances whenever the output can take it.
  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.registered   <= 1'b0;
      cfg_q.period_ticks <= fpts_pkg::PeriodW'(1);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == fpts_pkg::CFG_REGISTERED) begin
        cfg_q.registered <= cfg_data_i[0];
      end else begin
        cfg_q.period_ticks <= cfg_data_i;
      end
    end
  end

  // Input register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q.func          <= fpts_pkg::func_e'(s_axis_tuser_i);
      in_item_q.now_ticks     <= s_axis_tdata_i[63:0];
      in_item_q.core_match    <= s_axis_tdata_i[64];
      in_item_q.in_interrupt  <= s_axis_tdata_i[65];
      in_item_q.irq_on        <= s_axis_tdata_i[66];
      in_item_q.dispatch_busy <= s_axis_tdata_i[67];
    end
  end

  fpts_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_item_q),
    .cfg_i    (cfg_q),
    .result_o (core_res),
    .status_o (core_status)
  );

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_res_q.ticks_until_due,
                            out_res_q.invoke_handler, out_res_q.pending_out};
  assign m_axis_tuser_o  = out_res_q.outcome;

  // A word leaving the input register always yields a result next cycle.
  `FPTS_ASSERT_NEXT(a_fire_gives_result, clk_i, rst_ni, fire, out_valid_q)
  // The reported pending flag matches the stored request after each word.
  `FPTS_ASSERT_NEXT(a_pending_tracks_state, clk_i, rst_ni, fire, out_res_q.pending_out == core_status.pending)
  // A turn opens only through a served service begin.
  `FPTS_ASSERT_NEXT(a_turn_opens_served, clk_i, rst_ni,
    !core_status.in_turn && !(fire && core_res.outcome == fpts_pkg::OUT_SERVED),
    !core_status.in_turn)
  // Starting the handler clears the pending request.
  `FPTS_ASSERT_SAME(a_served_clears_pending, clk_i, rst_ni,
    out_valid_q && out_res_q.invoke_handler,
    !out_res_q.pending_out && out_res_q.outcome == fpts_pkg::OUT_SERVED)

endmodule
